[hw/rtl/vehist_pkg.sv]
// Shared types and constants for the variable-edge histogram block.
// Used by every module under hw/rtl; depends on nothing else.
package vehist_pkg;

  // Histogram geometry.
  localparam int NUM_BINS    = 7;
  localparam int COUNT_BITS  = 16;
  localparam int NUM_BOUNDS  = 8;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W    = 16;
  localparam int BOUND_W     = 16;
  localparam int BIN_W       = 3;
  localparam int OUT_COUNT_W = 16;

  // Configuration port.
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  // Queue between the classifier and the counter stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [BOUND_W-1:0] bound_t;
  typedef bound_t [NUM_BOUNDS-1:0]   bound_bank_t;
  typedef logic [COUNT_BITS-1:0]     count_t;

  // Classification of one sample, carried through the queue.
  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] bin;
  } class_t;

  // Reset values of the bin boundary registers.
  localparam bound_bank_t BOUND_RESET = '{
    16'sd24576, 16'sd16384, 16'sd8192, 16'sd0,
    -16'sd8192, -16'sd16384, -16'sd24576, -16'sd32768
  };

endpackage

[hw/rtl/vehist_front.sv]
// Front stage: accepts samples and finds their bin against the boundary registers.
// Depends on vehist_pkg; pushes one classification per item into vehist_queue.
module vehist_front (
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [vehist_pkg::SAMPLE_W-1:0]   sample,
  input  vehist_pkg::bound_bank_t                  bounds,
  input  logic                                     queue_full,
  output logic                                     push,
  output vehist_pkg::class_t                       push_data
);

  logic                               in_range;
  logic [vehist_pkg::BIN_W-1:0]       found;

  // The queue is the only thing that can hold the input back.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Range test against the outer boundaries.
  assign in_range = (sample >= bounds[0]) && (sample < bounds[vehist_pkg::NUM_BINS]);

  // Lowest bin whose upper boundary lies above the sample; all compares run in parallel.
  always_comb begin
    found = '0;
    for (int b = vehist_pkg::NUM_BINS - 1; b >= 0; b--) begin
      if (bounds[b+1] > sample) begin
        found = vehist_pkg::BIN_W'(b);
      end
    end
  end

  // Rejected samples carry bin zero.
  always_comb begin
    push_data.hit = in_range;
    push_data.bin = in_range ? found : '0;
  end

endmodule

[hw/rtl/vehist_queue.sv]
// Short first-in first-out queue of classified items between front and back.
// Depends on vehist_pkg for the entry type and depth.
module vehist_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vehist_pkg::class_t push_data,
  input  logic               pop,
  output vehist_pkg::class_t pop_data,
  output logic               not_empty,
  output logic               full
);

  vehist_pkg::class_t                    entries [vehist_pkg::QUEUE_DEPTH];
  logic [vehist_pkg::QUEUE_PTR_W-1:0]    head;
  logic [vehist_pkg::QUEUE_PTR_W-1:0]    tail;
  logic [vehist_pkg::QUEUE_CNT_W-1:0]    fill;

  assign not_empty = (fill != '0);
  assign full      = (fill == vehist_pkg::QUEUE_CNT_W'(vehist_pkg::QUEUE_DEPTH));
  assign pop_data  = entries[head];

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + vehist_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        head <= head + vehist_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + vehist_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - vehist_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/vehist_back.sv]
// Back stage: updates the saturating bin counters and holds the result register.
// Depends on vehist_pkg; drains items from vehist_queue.
module vehist_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 queue_not_empty,
  input  vehist_pkg::class_t                   queue_data,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic [vehist_pkg::BIN_W-1:0]         bin_index,
  output logic [vehist_pkg::OUT_COUNT_W-1:0]   bin_count
);

  vehist_pkg::count_t counts [vehist_pkg::NUM_BINS];
  vehist_pkg::count_t count_sel;
  vehist_pkg::count_t count_next;
  logic               bump;

  // Take an item whenever the result register is empty or being emptied.
  assign pop  = queue_not_empty && (!out_valid || !out_stall);
  assign bump = pop && queue_data.hit;

  // Saturating increment of the addressed counter.
  always_comb begin
    count_sel  = counts[queue_data.bin];
    count_next = (count_sel == '1) ? count_sel : count_sel + vehist_pkg::COUNT_BITS'(1);
  end

  // Counter bank, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < vehist_pkg::NUM_BINS; b++) begin
        counts[b] <= '0;
      end
    end else if (bump) begin
      counts[queue_data.bin] <= count_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; a rejected item reports zero bin and count.
  always_ff @(posedge clk) begin
    if (pop) begin
      accepted  <= queue_data.hit;
      bin_index <= queue_data.hit ? queue_data.bin : '0;
      bin_count <= queue_data.hit ? vehist_pkg::OUT_COUNT_W'(count_next) : '0;
    end
  end

endmodule

[hw/rtl/variable_edge_histogram_core.sv]
// Histogram with programmable bin boundaries: top level with the register port.
// Throughput: one item per cycle unless stalled, set by the single counter update
// in the back stage. Items pass through a queue entry and then the result register.
// A four-entry queue between classifier and counters lets input and output stall apart.
// Reset (synchronous, active high) clears all bin counts and restores the boundaries.
// Depends on vehist_pkg, vehist_front, vehist_queue and vehist_back.
module variable_edge_histogram_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [vehist_pkg::ADDR_W-1:0]            paddr,
  input  logic [vehist_pkg::DATA_W-1:0]            pwdata,
  output logic [vehist_pkg::DATA_W-1:0]            prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [vehist_pkg::SAMPLE_W-1:0]   sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     accepted,
  output logic [vehist_pkg::BIN_W-1:0]             bin_index,
  output logic [vehist_pkg::OUT_COUNT_W-1:0]       bin_count
);

  vehist_pkg::bound_bank_t             bounds;
  logic [vehist_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                                reg_write;
  logic                                push;
  vehist_pkg::class_t                  push_data;
  logic                                pop;
  vehist_pkg::class_t                  pop_data;
  logic                                queue_not_empty;
  logic                                queue_full;

  // Register port: word-aligned, always ready.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[vehist_pkg::ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = vehist_pkg::DATA_W'(bounds[reg_idx]);

  // Boundary registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= vehist_pkg::BOUND_RESET;
    end else if (reg_write) begin
      bounds[reg_idx] <= pwdata[vehist_pkg::BOUND_W-1:0];
    end
  end

  vehist_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .bounds     (bounds),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  vehist_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_not_empty),
    .full      (queue_full)
  );

  vehist_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .queue_data      (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .bin_index       (bin_index),
    .bin_count       (bin_count)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for variable_edge_histogram_core: edge registers over APB,
// sample items in, one checked result item out per sample. Depends on vehist_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;
  localparam int BURST_BIN_ITEMS = 64;

  // Expected content of one result item.
  typedef struct packed {
    logic                               accepted;
    logic [vehist_pkg::BIN_W-1:0]       bin;
    logic [vehist_pkg::OUT_COUNT_W-1:0] count;
  } bin_result_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic [vehist_pkg::ADDR_W-1:0]          paddr;
  logic [vehist_pkg::DATA_W-1:0]          pwdata;
  logic [vehist_pkg::DATA_W-1:0]          prdata;
  logic                                   pready;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [vehist_pkg::SAMPLE_W-1:0] sample;
  logic                                   out_valid;
  logic                                   out_stall;
  logic                                   accepted;
  logic [vehist_pkg::BIN_W-1:0]           bin_index;
  logic [vehist_pkg::OUT_COUNT_W-1:0]     bin_count;

  // Shadow copy of the edges and the bin counters.
  vehist_pkg::bound_t edge_shadow [vehist_pkg::NUM_BOUNDS];
  vehist_pkg::bound_t edge_plan   [vehist_pkg::NUM_BOUNDS];
  vehist_pkg::count_t bin_tally   [vehist_pkg::NUM_BINS];
  bin_result_t        expected_bins [$];
  bin_result_t        head_result;

  int          cycle_count;
  int          mismatches;
  int          samples_sent;
  int          rejects_seen;
  int          saturated_hits;
  int          edge_settings;
  bit          stall_enable;
  bit          gaps_enable;
  logic [15:0] stall_pattern;
  int          stall_left;
  logic [3:0]  stall_phase;

  variable_edge_histogram_core u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted),
    .bin_index (bin_index),
    .bin_count (bin_count)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_bins.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall: a random 16-bit pattern, replaced after a random interval,
  // sometimes all clear so that stretches without stalls occur.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 48);
      case ($urandom_range(0, 3))
        0: stall_pattern = 16'h0000;
        1: stall_pattern = 16'($urandom);
        2: stall_pattern = 16'($urandom & $urandom);
        default: stall_pattern = 16'($urandom | $urandom);
      endcase
    end
    stall_left--;
    stall_phase++;
    out_stall = stall_enable && stall_pattern[stall_phase];
  end

  // Record a mismatch; only the first few are printed.
  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("Mismatch at cycle %0d: %s expected %0d, got %0d",
               cycle_count, what, want, got);
  endtask

  // Predict the result of one sample and update the shadow counters.
  function automatic bin_result_t classify_sample(vehist_pkg::bound_t s);
    bin_result_t r;
    int          b;
    int          hit;
    r   = '0;
    hit = -1;
    if (s < edge_shadow[0] || s >= edge_shadow[vehist_pkg::NUM_BINS])
      return r;
    // Search upward for the first bin whose upper edge lies above the sample.
    for (b = 0; b < vehist_pkg::NUM_BINS; b++) begin
      if (edge_shadow[b+1] > s) begin
        hit = b;
        break;
      end
    end
    if (hit < 0)
      return r;
    if (bin_tally[hit] != '1)
      bin_tally[hit]++;
    else
      saturated_hits++;
    r.accepted = 1'b1;
    r.bin      = hit[vehist_pkg::BIN_W-1:0];
    r.count    = bin_tally[hit][vehist_pkg::OUT_COUNT_W-1:0];
    return r;
  endfunction

  // Result checker: each accepted result item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bins.size() == 0) begin
        note_mismatch("result with none expected, bin_index", 0, bin_index);
      end else begin
        head_result = expected_bins.pop_front();
        if (accepted !== head_result.accepted)
          note_mismatch("accepted", head_result.accepted, accepted);
        if (bin_index !== head_result.bin)
          note_mismatch("bin_index", head_result.bin, bin_index);
        if (bin_count !== head_result.count)
          note_mismatch("bin_count", head_result.count, bin_count);
      end
    end
  end

  // Send one sample item; valid stays high afterwards for a following item.
  task automatic send_sample(input vehist_pkg::bound_t value);
    bin_result_t r;
    @(negedge clk);
    in_valid = 1'b1;
    sample   = value;
    do @(posedge clk); while (in_stall);
    r = classify_sample(value);
    if (!r.accepted)
      rejects_seen++;
    samples_sent++;
    expected_bins = {expected_bins, r};
  endtask

  // Hold the input idle for the given number of cycles, with noise on the payload.
  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
      sample   = 16'($urandom);
    end
  endtask

  // Wait until every expected result has arrived, plus a short settle.
  task automatic wait_drained();
    while (expected_bins.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_edge(input int idx, input vehist_pkg::bound_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = vehist_pkg::ADDR_W'(idx << 2);
    pwdata  = vehist_pkg::DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    edge_shadow[idx] = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_edge(input int idx);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = vehist_pkg::ADDR_W'(idx << 2);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[vehist_pkg::BOUND_W-1:0] !== edge_shadow[idx])
      note_mismatch($sformatf("edge_%0d read back", idx), edge_shadow[idx],
                    $signed(prdata[vehist_pkg::BOUND_W-1:0]));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write the planned edges once the block is idle, then read them back.
  task automatic load_edge_plan();
    int i;
    idle_input(1);
    wait_drained();
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      write_edge(i, edge_plan[i]);
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      read_edge(i);
    edge_settings++;
  endtask

  // Random sample: uniform, next to an edge, or inside the edge range.
  function automatic vehist_pkg::bound_t pick_sample();
    int          k;
    int          lo;
    int          hi;
    logic [15:0] bits;
    bits = 16'($urandom);
    lo   = edge_shadow[0];
    hi   = edge_shadow[vehist_pkg::NUM_BINS];
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5, 6: begin
        k    = $urandom_range(0, vehist_pkg::NUM_BOUNDS - 1);
        bits = 16'(edge_shadow[k] + $urandom_range(0, 2) - 1);
      end
      default: begin
        if (lo < hi)
          bits = 16'(lo + $urandom_range(0, hi - lo - 1));
      end
    endcase
    return vehist_pkg::bound_t'(bits);
  endfunction

  // Stream of samples in bursts of random length, with random gaps when gaps are enabled.
  task automatic stream_samples(input int total);
    int left;
    int burst;
    left = total;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left)
        burst = left;
      repeat (burst) send_sample(pick_sample());
      left -= burst;
      if (gaps_enable && $urandom_range(0, 3) != 0)
        idle_input($urandom_range(1, 6));
    end
    idle_input(1);
  endtask

  // Reset edges read back, then samples on and around the default edges.
  task automatic test_default_bins();
    int i;
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      read_edge(i);
    send_sample(-16'sd32768);
    send_sample(-16'sd24577);
    send_sample(-16'sd24576);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd24575);
    send_sample(16'sd24576);
    send_sample(16'sd32767);
    idle_input(1);
  endtask

  // Range limits: a narrow range, then the full signed range.
  task automatic test_range_limits();
    int i;
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      edge_plan[i] = (i == vehist_pkg::NUM_BINS) ? 16'sd100 :
                     vehist_pkg::bound_t'(-100 + 30 * i);
    load_edge_plan();
    send_sample(-16'sd101);
    send_sample(-16'sd100);
    send_sample(16'sd99);
    send_sample(16'sd100);
    idle_input(1);
    edge_plan[0] = -16'sd32768;
    for (i = 1; i < vehist_pkg::NUM_BINS; i++)
      edge_plan[i] = vehist_pkg::bound_t'(i - 2);
    edge_plan[vehist_pkg::NUM_BINS] = 16'sd32767;
    load_edge_plan();
    send_sample(16'sd32766);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd2);
    idle_input(1);
  endtask

  // Edges out of order, and an empty range where the top edge is below the bottom.
  task automatic test_unordered_edges();
    edge_plan = '{-16'sd1000, 16'sd500, -16'sd500, 16'sd200,
                  16'sd800, 16'sd100, 16'sd900, 16'sd1000};
    load_edge_plan();
    send_sample(-16'sd1000);
    send_sample(16'sd600);
    send_sample(16'sd950);
    send_sample(16'sd1000);
    idle_input(1);
    edge_plan[0]                    = 16'sd100;
    edge_plan[vehist_pkg::NUM_BINS] = -16'sd100;
    load_edge_plan();
    send_sample(16'sd0);
    send_sample(16'sd100);
    idle_input(1);
  endtask

  // Random samples over several edge settings, with a full drain mid-phase.
  task automatic test_random_settings();
    int                 phase;
    int                 i;
    int                 j;
    int                 base;
    vehist_pkg::bound_t t;
    stall_enable = 1'b1;
    gaps_enable  = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++) begin
        t = 16'($urandom);
        case (phase)
          0: edge_plan[i] = vehist_pkg::BOUND_RESET[i];
          3: edge_plan[i] = (i == vehist_pkg::NUM_BINS) ? 16'sd32767 :
                            vehist_pkg::bound_t'(-32768 + 9362 * i);
          5: edge_plan[i] = t & 16'hF000;
          default: edge_plan[i] = t;
        endcase
      end
      if (phase == 4) begin
        base = $urandom_range(0, 65500) - 32768;
        for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
          edge_plan[i] = vehist_pkg::bound_t'(base + i * $urandom_range(1, 4));
      end
      // Ascending order for the sorted settings; the others keep the order they were built with.
      if (phase == 1 || phase == 5) begin
        for (i = 0; i < vehist_pkg::NUM_BOUNDS - 1; i++)
          for (j = 0; j < vehist_pkg::NUM_BOUNDS - 1 - i; j++)
            if (edge_plan[j] > edge_plan[j+1]) begin
              t              = edge_plan[j];
              edge_plan[j]   = edge_plan[j+1];
              edge_plan[j+1] = t;
            end
      end
      load_edge_plan();
      stream_samples(140);
      wait_drained();
      stream_samples(140);
    end
  endtask

  // Back-to-back hits on one bin at full rate, then a stalled random stream.
  task automatic test_single_bin_burst();
    int i;
    int v;
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      edge_plan[i] = vehist_pkg::BOUND_RESET[i];
    stall_enable = 1'b0;
    gaps_enable  = 1'b0;
    load_edge_plan();
    repeat (BURST_BIN_ITEMS) begin
      v = $urandom_range(1, 8192);
      send_sample(vehist_pkg::bound_t'(-v));
    end
    idle_input(1);
    stall_enable = 1'b1;
    gaps_enable  = 1'b1;
    stream_samples(60);
  endtask

  initial begin
    int i;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    sample       = '0;
    out_stall    = 1'b0;
    stall_enable = 1'b0;
    gaps_enable  = 1'b0;
    stall_left   = 0;
    stall_phase  = '0;
    cycle_count  = 0;
    mismatches   = 0;
    samples_sent = 0;
    rejects_seen = 0;
    saturated_hits = 0;
    edge_settings  = 1;
    for (i = 0; i < vehist_pkg::NUM_BOUNDS; i++)
      edge_shadow[i] = vehist_pkg::BOUND_RESET[i];
    for (i = 0; i < vehist_pkg::NUM_BINS; i++)
      bin_tally[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_bins();
    test_range_limits();
    test_unordered_edges();
    test_random_settings();
    test_single_bin_burst();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d samples over %0d edge settings, %0d rejected,",
             samples_sent, edge_settings, rejects_seen);
    $display("and %0d hits on a full counter; %0d mismatches, %0d results outstanding.",
             saturated_hits, mismatches, expected_bins.size());
    if (mismatches == 0 && expected_bins.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[variable_edge_histogram_core.f]
hw/rtl/vehist_pkg.sv
hw/rtl/vehist_front.sv
hw/rtl/vehist_queue.sv
hw/rtl/vehist_back.sv
hw/rtl/variable_edge_histogram_core.sv
sim/tb.sv
